[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the RTL; clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define VRDS_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define VRDS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hdl/vrds_pkg.sv]
// ----------------------------------------------------------------------------
// vrds_pkg
// Request and result types, codes and fixed constants of the ray stepper.
// ----------------------------------------------------------------------------
`default_nettype none

package vrds_pkg;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [23:0] origin_x;
        logic signed [23:0] origin_y;
        logic signed [23:0] origin_z;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
        logic [3:0]         child_log_x;
        logic [3:0]         child_log_y;
        logic [3:0]         child_log_z;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] cell_x;
        logic signed [15:0] cell_y;
        logic signed [15:0] cell_z;
        logic [1:0]         last_axis;
        logic [31:0]        hit_distance;
        logic [15:0]        unit_steps_taken;
        logic               out_of_range;
        logic               steps_exhausted;
    } t_out_item;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SQ,
        S_SQ_ACC,
        S_SQRT,
        S_UM,
        S_UM_DONE,
        S_DELTA_DONE,
        S_SIDE,
        S_DIV,
        S_STEP,
        S_SKIP,
        S_SKMUL,
        S_SKACC,
        S_SKPICK,
        S_SKLOOP,
        S_HIT,
        S_HIT_DONE,
        S_OUT
    } t_state;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_STEP  = 2'd1;
    localparam logic [1:0] OP_SKIP  = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    localparam logic [1:0] CFG_MAX_DISTANCE = 2'd0;
    localparam logic [1:0] CFG_MAX_STEPS    = 2'd1;

    localparam int DIV_W      = 48;
    localparam int SQRT_ITER  = 16;
    localparam logic [31:0] ALL32 = 32'hFFFF_FFFF;

endpackage

`default_nettype wire

[hdl/voxel_ray_dda_stepper.sv]
// ----------------------------------------------------------------------------
// voxel_ray_dda_stepper
// Fixed-point 3D voxel grid ray walker with unit steps and node skips.
// ----------------------------------------------------------------------------
// One request is taken at a time and gives one result. A start request
// squares the direction on a shared 32x16 multiplier, takes a 16-iteration
// square root, then per axis runs the shared restoring divider for the
// unit component and, if that is nonzero, again for the delta distance.
// Most of a unit step is the divider that forms the hit distance. A node
// skip walks at most 4 << MAX_CHILD_LOG unit steps. The next request
// is taken while a finished result still waits in the output register.
`default_nettype none
`include "assert_macros.svh"

module voxel_ray_dda_stepper #(
    parameter int MAX_CHILD_LOG = 7
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  vrds_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output vrds_pkg::t_out_item  o_out_item,
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire [1:0]            i_cfg_index,
    input  wire [31:0]           i_cfg_data
);
    import vrds_pkg::*;

    localparam int SKIP_CAP = 4 << MAX_CHILD_LOG;
    localparam int SKIP_W   = $clog2(SKIP_CAP + 1);

    // Axis with the smallest distance; x wins only when strictly smallest, a y-z tie goes to z.
    function automatic logic [1:0] f_pick(input logic [31:0] d0, input logic [31:0] d1,
                                          input logic [31:0] d2);
        if (d0 < d1 && d0 < d2) begin
            return AX_X;
        end
        if (d1 < d2) begin
            return AX_Y;
        end
        return AX_Z;
    endfunction

    // Control and architectural state
    t_state               r_state, n_state;
    t_state               r_ret, n_ret;
    logic [31:0]          r_maxd, n_maxd;
    logic [15:0]          r_maxs, n_maxs;
    logic signed [23:0]   r_org [3], n_org [3];
    logic signed [15:0]   r_udir [3], n_udir [3];
    logic [31:0]          r_delta [3], n_delta [3];
    logic [31:0]          r_side [3], n_side [3];
    logic [15:0]          r_cell [3], n_cell [3];
    logic                 r_neg [3], n_neg [3];
    logic [1:0]           r_crossed, n_crossed;
    logic [15:0]          r_adv, n_adv;
    logic                 r_o_valid, n_o_valid;

    // Working registers
    t_in_item             r_item, n_item;
    t_out_item            r_o_item, n_o_item;
    logic [1:0]           r_idx, n_idx;
    logic [5:0]           r_cnt, n_cnt;
    logic [31:0]          r_acc, n_acc;
    logic [31:0]          r_sv, n_sv;
    logic [31:0]          r_sr, n_sr;
    logic [31:0]          r_sb, n_sb;
    logic [DIV_W-1:0]     r_dq, n_dq;
    logic [15:0]          r_rem, n_rem;
    logic [15:0]          r_dvs, n_dvs;
    logic [47:0]          r_prod;
    logic [31:0]          r_mul [3], n_mul [3];
    logic [15:0]          r_ns [3], n_ns [3];
    logic [1:0]           r_sk_ax, n_sk_ax;
    logic [15:0]          r_target, n_target;
    logic [SKIP_W-1:0]    r_steps, n_steps;
    logic [31:0]          r_hit, n_hit;

    // Shared multiplier operands
    logic [31:0]          w_ma;
    logic [15:0]          w_mb;

    // Per-axis views of the held request
    logic signed [23:0]   w_org_in [3];
    logic signed [15:0]   w_dir_in [3];
    logic [3:0]           w_log_in [3];
    logic [15:0]          w_dmag [3];

    // Unit step
    logic [1:0]           w_ax;
    logic [32:0]          w_side_sum;
    logic [31:0]          w_step_side;
    logic [15:0]          w_step_cell;
    logic                 w_do_step;

    // Divider and square root steps
    logic [16:0]          w_dtmp;
    logic                 w_dge;
    logic [16:0]          w_drem;
    logic [32:0]          w_rb;

    // Node skip boundary counts
    logic [15:0]          w_ns [3];
    logic                 w_bnd;

    // Hit distance
    logic [1:0]           w_hax;
    logic signed [15:0]   w_u;
    logic signed [25:0]   w_num;
    logic [25:0]          w_num_abs;
    logic [15:0]          w_u_abs;

    logic [15:0]          w_um;
    logic [15:0]          w_side_fac;
    logic [31:0]          w_steps32;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_o_valid;
    assign o_out_item  = r_o_item;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        w_org_in[0] = r_item.origin_x;
        w_org_in[1] = r_item.origin_y;
        w_org_in[2] = r_item.origin_z;
        w_dir_in[0] = r_item.dir_x;
        w_dir_in[1] = r_item.dir_y;
        w_dir_in[2] = r_item.dir_z;
        w_log_in[0] = r_item.child_log_x;
        w_log_in[1] = r_item.child_log_y;
        w_log_in[2] = r_item.child_log_z;
        for (int a = 0; a < 3; a++) begin
            w_dmag[a] = w_dir_in[a][15] ? (16'd0 - w_dir_in[a]) : w_dir_in[a];
        end
    end

    // Unit step along the axis with the smallest side distance
    always_comb begin
        w_ax        = f_pick(r_side[0], r_side[1], r_side[2]);
        w_side_sum  = {1'b0, r_side[w_ax]} + {1'b0, r_delta[w_ax]};
        w_step_side = w_side_sum[32] ? ALL32 : w_side_sum[31:0];
        w_step_cell = r_cell[w_ax] + (r_neg[w_ax] ? 16'hFFFF : 16'd1);
    end

    // One restoring divide bit and one square root digit per cycle
    always_comb begin
        w_dtmp = {r_rem, r_dq[DIV_W-1]};
        w_dge  = (w_dtmp >= {1'b0, r_dvs});
        w_drem = w_dge ? (w_dtmp - {1'b0, r_dvs}) : w_dtmp;
        w_rb   = {1'b0, r_sr} + {1'b0, r_sb};
    end

    // Distance to the node boundary per axis, in cells
    always_comb begin
        logic [3:0]  lg;
        logic [15:0] ext;
        logic [15:0] low;
        w_bnd = 1'b0;
        for (int a = 0; a < 3; a++) begin
            lg  = (32'(w_log_in[a]) > MAX_CHILD_LOG) ? 4'(MAX_CHILD_LOG) : w_log_in[a];
            ext = 16'd1 << lg;
            low = r_cell[a] & (ext - 16'd1);
            if (r_neg[a]) begin
                w_ns[a] = low;
                if (low == 16'd0) begin
                    w_bnd = 1'b1;
                end
            end else begin
                w_ns[a] = ext - low;
            end
        end
    end

    // Hit distance numerator on the crossed axis
    always_comb begin
        w_hax     = (r_crossed == AX_Z || r_crossed == 2'd3) ? AX_Z : r_crossed;
        w_u       = r_udir[w_hax];
        w_num     = $signed({{2{r_cell[w_hax][15]}}, r_cell[w_hax], 8'd0})
                  - $signed({{2{r_org[w_hax][23]}}, r_org[w_hax]})
                  + (r_neg[w_hax] ? 26'sd256 : 26'sd0);
        w_num_abs = w_num[25] ? (26'd0 - w_num) : w_num;
        w_u_abs   = w_u[15] ? (16'd0 - w_u) : w_u;
    end

    always_comb begin
        w_um       = (r_sr[15:0] == 16'd0) ? 16'd0 : r_dq[15:0];
        w_side_fac = r_neg[r_idx] ? {8'd0, w_org_in[r_idx][7:0]}
                                  : 16'd256 - {8'd0, w_org_in[r_idx][7:0]};
        w_steps32  = 32'(r_steps);
    end

    // Sequencer: next state and datapath control
    always_comb begin
        n_state   = r_state;
        n_ret     = r_ret;
        n_maxd    = r_maxd;
        n_maxs    = r_maxs;
        n_org     = r_org;
        n_udir    = r_udir;
        n_delta   = r_delta;
        n_side    = r_side;
        n_cell    = r_cell;
        n_neg     = r_neg;
        n_crossed = r_crossed;
        n_adv     = r_adv;
        n_o_valid = r_o_valid;
        n_item    = r_item;
        n_o_item  = r_o_item;
        n_idx     = r_idx;
        n_cnt     = r_cnt;
        n_acc     = r_acc;
        n_sv      = r_sv;
        n_sr      = r_sr;
        n_sb      = r_sb;
        n_dq      = r_dq;
        n_rem     = r_rem;
        n_dvs     = r_dvs;
        n_mul     = r_mul;
        n_ns      = r_ns;
        n_sk_ax   = r_sk_ax;
        n_target  = r_target;
        n_steps   = r_steps;
        n_hit     = r_hit;
        w_ma      = 32'd0;
        w_mb      = 16'd0;
        w_do_step = 1'b0;

        if (r_o_valid && i_out_ready) begin
            n_o_valid = 1'b0;
        end

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MAX_DISTANCE: n_maxd = i_cfg_data;
                CFG_MAX_STEPS:    n_maxs = i_cfg_data[15:0];
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in_item;
                    n_steps = '0;
                    n_hit   = 32'd0;
                    n_idx   = 2'd0;
                    unique case (i_in_item.operation)
                        OP_START: begin
                            n_acc     = 32'd0;
                            n_crossed = AX_X;
                            n_adv     = 16'd0;
                            n_state   = S_SQ;
                        end
                        OP_STEP, OP_SKIP: begin
                            if (r_adv != 16'hFFFF) begin
                                n_adv = r_adv + 16'd1;
                            end
                            n_state = (i_in_item.operation == OP_STEP) ? S_STEP : S_SKIP;
                        end
                        default: n_state = S_HIT;
                    endcase
                end
            end
            S_SQ: begin
                w_ma    = {16'd0, w_dmag[r_idx]};
                w_mb    = w_dmag[r_idx];
                n_state = S_SQ_ACC;
            end
            S_SQ_ACC: begin
                n_acc = r_acc + r_prod[31:0];
                if (r_idx == AX_Z) begin
                    n_sv    = r_acc + r_prod[31:0];
                    n_sr    = 32'd0;
                    n_sb    = 32'h4000_0000;
                    n_cnt   = 6'd0;
                    n_idx   = 2'd0;
                    n_state = S_SQRT;
                end else begin
                    n_idx   = r_idx + 2'd1;
                    n_state = S_SQ;
                end
            end
            S_SQRT: begin
                if ({1'b0, r_sv} >= w_rb) begin
                    n_sv = r_sv - w_rb[31:0];
                    n_sr = (r_sr >> 1) + r_sb;
                end else begin
                    n_sr = r_sr >> 1;
                end
                n_sb  = r_sb >> 2;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'(SQRT_ITER - 1)) begin
                    n_state = S_UM;
                end
            end
            S_UM: begin
                // unit component = |d| * 2^14 / length
                n_dq    = DIV_W'({w_dmag[r_idx], 14'd0});
                n_rem   = 16'd0;
                n_dvs   = r_sr[15:0];
                n_cnt   = 6'd0;
                n_ret   = S_UM_DONE;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_rem = w_drem[15:0];
                n_dq  = {r_dq[DIV_W-2:0], w_dge};
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'(DIV_W - 1)) begin
                    n_state = r_ret;
                end
            end
            S_UM_DONE: begin
                n_org[r_idx]  = w_org_in[r_idx];
                n_cell[r_idx] = w_org_in[r_idx][23:8];
                n_neg[r_idx]  = (w_um != 16'd0) && w_dir_in[r_idx][15];
                n_udir[r_idx] = ((w_um != 16'd0) && w_dir_in[r_idx][15]) ? (16'd0 - w_um) : w_um;
                if (w_um == 16'd0) begin
                    // flat axis saturates and wins a compare only on a tie of saturated distances
                    n_delta[r_idx] = ALL32;
                    n_side[r_idx]  = ALL32;
                    if (r_idx == AX_Z) begin
                        n_state = S_OUT;
                    end else begin
                        n_idx   = r_idx + 2'd1;
                        n_state = S_UM;
                    end
                end else begin
                    n_dq    = DIV_W'(32'h4000_0000);
                    n_rem   = 16'd0;
                    n_dvs   = w_um;
                    n_cnt   = 6'd0;
                    n_ret   = S_DELTA_DONE;
                    n_state = S_DIV;
                end
            end
            S_DELTA_DONE: begin
                n_delta[r_idx] = r_dq[31:0];
                w_ma           = r_dq[31:0];
                w_mb           = w_side_fac;
                n_state        = S_SIDE;
            end
            S_SIDE: begin
                n_side[r_idx] = r_prod[39:8];
                if (r_idx == AX_Z) begin
                    n_state = S_OUT;
                end else begin
                    n_idx   = r_idx + 2'd1;
                    n_state = S_UM;
                end
            end
            S_STEP: begin
                w_do_step = 1'b1;
                n_steps   = SKIP_W'(1);
                n_state   = S_HIT;
            end
            S_SKIP: begin
                if (w_bnd) begin
                    // sitting on a node face backward: one plain step
                    w_do_step = 1'b1;
                    n_steps   = SKIP_W'(1);
                    n_state   = S_HIT;
                end else begin
                    n_ns    = w_ns;
                    n_idx   = 2'd0;
                    n_state = S_SKMUL;
                end
            end
            S_SKMUL: begin
                w_ma    = r_delta[r_idx];
                w_mb    = r_ns[r_idx];
                n_state = S_SKACC;
            end
            S_SKACC: begin
                n_mul[r_idx] = (r_prod[47:32] != 16'd0) ? ALL32 : r_prod[31:0];
                if (r_idx == AX_Z) begin
                    n_state = S_SKPICK;
                end else begin
                    n_idx   = r_idx + 2'd1;
                    n_state = S_SKMUL;
                end
            end
            S_SKPICK: begin
                n_sk_ax  = f_pick(r_mul[0], r_mul[1], r_mul[2]);
                n_target = r_neg[f_pick(r_mul[0], r_mul[1], r_mul[2])]
                         ? r_cell[f_pick(r_mul[0], r_mul[1], r_mul[2])]
                           - r_ns[f_pick(r_mul[0], r_mul[1], r_mul[2])]
                         : r_cell[f_pick(r_mul[0], r_mul[1], r_mul[2])]
                           + r_ns[f_pick(r_mul[0], r_mul[1], r_mul[2])];
                n_state  = S_SKLOOP;
            end
            S_SKLOOP: begin
                if (r_cell[r_sk_ax] != r_target && w_steps32 < 32'(SKIP_CAP)) begin
                    w_do_step = 1'b1;
                    n_steps   = r_steps + SKIP_W'(1);
                end else begin
                    n_state = S_HIT;
                end
            end
            S_HIT: begin
                if (w_u == 16'sd0) begin
                    n_hit   = ALL32;
                    n_state = S_OUT;
                end else if (w_num == 26'sd0 || (w_num[25] != w_u[15])) begin
                    n_hit   = 32'd0;
                    n_state = S_OUT;
                end else begin
                    n_dq    = {1'b0, w_num_abs[24:0], 22'd0};
                    n_rem   = 16'd0;
                    n_dvs   = w_u_abs;
                    n_cnt   = 6'd0;
                    n_ret   = S_HIT_DONE;
                    n_state = S_DIV;
                end
            end
            S_HIT_DONE: begin
                n_hit   = (r_dq[47:32] != 16'd0) ? ALL32 : r_dq[31:0];
                n_state = S_OUT;
            end
            S_OUT: begin
                // hold until the output register is free
                if (!r_o_valid || i_out_ready) begin
                    n_o_item.cell_x           = r_cell[0];
                    n_o_item.cell_y           = r_cell[1];
                    n_o_item.cell_z           = r_cell[2];
                    n_o_item.last_axis        = r_crossed;
                    n_o_item.hit_distance     = r_hit;
                    n_o_item.unit_steps_taken = (w_steps32 > 32'h0000_FFFF) ? 16'hFFFF
                                                                            : w_steps32[15:0];
                    n_o_item.out_of_range     = (r_hit >= r_maxd);
                    n_o_item.steps_exhausted  = (r_adv >= r_maxs);
                    n_o_valid                 = 1'b1;
                    n_state                   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (w_do_step) begin
            n_side[w_ax] = w_step_side;
            n_cell[w_ax] = w_step_cell;
            n_crossed    = w_ax;
        end
    end

    // Control and ray state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ret     <= S_IDLE;
            r_maxd    <= 32'h0100_0000;
            r_maxs    <= 16'd1024;
            r_crossed <= AX_X;
            r_adv     <= 16'd0;
            r_o_valid <= 1'b0;
            for (int a = 0; a < 3; a++) begin
                r_org[a]   <= '0;
                r_udir[a]  <= '0;
                r_delta[a] <= ALL32;
                r_side[a]  <= ALL32;
                r_cell[a]  <= 16'd0;
                r_neg[a]   <= 1'b0;
            end
        end else begin
            r_state   <= n_state;
            r_ret     <= n_ret;
            r_maxd    <= n_maxd;
            r_maxs    <= n_maxs;
            r_crossed <= n_crossed;
            r_adv     <= n_adv;
            r_o_valid <= n_o_valid;
            r_org     <= n_org;
            r_udir    <= n_udir;
            r_delta   <= n_delta;
            r_side    <= n_side;
            r_cell    <= n_cell;
            r_neg     <= n_neg;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_o_item <= n_o_item;
        r_idx    <= n_idx;
        r_cnt    <= n_cnt;
        r_acc    <= n_acc;
        r_sv     <= n_sv;
        r_sr     <= n_sr;
        r_sb     <= n_sb;
        r_dq     <= n_dq;
        r_rem    <= n_rem;
        r_dvs    <= n_dvs;
        r_prod   <= w_ma * w_mb;
        r_mul    <= n_mul;
        r_ns     <= n_ns;
        r_sk_ax  <= n_sk_ax;
        r_target <= n_target;
        r_steps  <= n_steps;
        r_hit    <= n_hit;
    end

    `VRDS_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready)
    `VRDS_ASSERT_NOW(a_crossed_axis_legal, 1'b1, r_crossed != 2'd3)
    `VRDS_ASSERT_NOW(a_flat_axis_delta, r_udir[0] == 16'sd0, r_delta[0] == ALL32)

endmodule

`default_nettype wire

[bench/voxel_ray_dda_stepper_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_ray_dda_stepper_test
// Self-checking bench: directed table, then randomized ray walks per config.
// ----------------------------------------------------------------------------
// A local fixed-point ray walker tracks the stepper's state and predicts
// every result at request acceptance. Results are matched in order, field
// by field. The sender runs in bursts and gaps, the receiver stalls on its
// own pattern and once holds off for a long stretch to back the block up.
// Configuration is rewritten between phases, only with the block drained.
// ----------------------------------------------------------------------------
`default_nettype none

module voxel_ray_dda_stepper_test;
    import vrds_pkg::*;

    localparam int MAX_CHILD_LOG = 7;
    localparam int SKIP_CAP      = 4 << MAX_CHILD_LOG;
    localparam int RANDOM_ITEMS  = 1600;
    localparam int PHASES        = 5;
    localparam int CYCLE_LIMIT   = 4_000_000;
    localparam int DRAIN_CYCLES  = 700;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    t_in_item   in_item = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    t_out_item  out_item;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = CFG_MAX_DISTANCE;
    logic [31:0] cfg_data = '0;

    // Typed expectation riding along with the current request, if any.
    logic       fixed_pending = 1'b0;
    t_out_item  fixed_result = '0;

    voxel_ray_dda_stepper #(.MAX_CHILD_LOG(MAX_CHILD_LOG)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Ray walker state, mirrored from the block's behavior.
    // ------------------------------------------------------------------
    logic [31:0]        lim_distance = 32'd16777216;
    logic [15:0]        lim_steps    = 16'd1024;
    logic signed [23:0] ray_origin [3];
    int                 ray_unit   [3];
    logic [31:0]        ray_delta  [3];
    logic [31:0]        ray_side   [3];
    logic [15:0]        ray_cell   [3];
    bit                 ray_neg    [3];
    logic [1:0]         ray_axis;
    int unsigned        ray_advances;

    t_out_item   expected_results [$];
    int unsigned mismatch_count = 0;

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r = 0;
        longint unsigned b = 64'h4000_0000_0000_0000;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [31:0] sat_u32(longint unsigned v);
        return (v > 64'hFFFF_FFFF) ? ALL32 : v[31:0];
    endfunction

    // Smallest wins; x only when strictly smallest, a y-z tie goes to z.
    function automatic int nearest_axis(logic [31:0] d0, logic [31:0] d1, logic [31:0] d2);
        if (d0 < d1 && d0 < d2) return AX_X;
        if (d1 < d2) return AX_Y;
        return AX_Z;
    endfunction

    function automatic void walk_one_voxel();
        int a;
        a = nearest_axis(ray_side[0], ray_side[1], ray_side[2]);
        ray_side[a] = sat_u32(longint'(ray_side[a]) + longint'(ray_delta[a]));
        ray_cell[a] = ray_cell[a] + (ray_neg[a] ? 16'hFFFF : 16'd1);
        ray_axis    = a[1:0];
    endfunction

    function automatic void load_ray(input t_in_item r);
        longint signed   d [3];
        longint signed   o [3];
        longint unsigned len, mag, um;
        int unsigned     frac;
        d[0] = r.dir_x; d[1] = r.dir_y; d[2] = r.dir_z;
        o[0] = r.origin_x; o[1] = r.origin_y; o[2] = r.origin_z;
        len = int_sqrt(d[0] * d[0] + d[1] * d[1] + d[2] * d[2]);
        for (int a = 0; a < 3; a++) begin
            mag  = (d[a] < 0) ? -d[a] : d[a];
            um   = (len == 0) ? 0 : (mag * 16384) / len;
            frac = 32'(o[a] & 255);
            ray_origin[a] = o[a][23:0];
            ray_cell[a]   = o[a][23:8];
            ray_neg[a]    = (um != 0) && (d[a] < 0);
            ray_unit[a]   = ray_neg[a] ? -int'(um) : int'(um);
            if (um == 0) begin
                ray_delta[a] = ALL32;
                ray_side[a]  = ALL32;
            end else begin
                ray_delta[a] = 32'((64'd1 << 30) / um);
                ray_side[a]  = 32'(((ray_neg[a] ? longint'(frac) : longint'(256 - frac))
                                    * longint'(ray_delta[a])) >> 8);
            end
        end
        ray_axis     = AX_X;
        ray_advances = 0;
    endfunction

    function automatic int unsigned skip_to_node(input t_in_item r);
        int unsigned     lg [3];
        int unsigned     span [3];
        logic [31:0]     cost [3];
        int unsigned     walked = 0;
        int unsigned     ext, low;
        int              a;
        logic [15:0]     goal;
        lg[0] = r.child_log_x; lg[1] = r.child_log_y; lg[2] = r.child_log_z;
        for (int k = 0; k < 3; k++) begin
            if (lg[k] > MAX_CHILD_LOG) lg[k] = MAX_CHILD_LOG;
            ext = 1 << lg[k];
            low = ray_cell[k] & (ext - 1);
            if (ray_neg[k]) begin
                // Sitting on the boundary while stepping back: one voxel only.
                if (low == 0) begin
                    walk_one_voxel();
                    return 1;
                end
                span[k] = low;
            end else begin
                span[k] = ext - low;
            end
        end
        for (int k = 0; k < 3; k++)
            cost[k] = sat_u32(longint'(span[k]) * longint'(ray_delta[k]));
        a = nearest_axis(cost[0], cost[1], cost[2]);
        goal = ray_neg[a] ? ray_cell[a] - span[a][15:0] : ray_cell[a] + span[a][15:0];
        while (ray_cell[a] != goal && walked < SKIP_CAP) begin
            walk_one_voxel();
            walked++;
        end
        return walked;
    endfunction

    function automatic logic [31:0] face_distance();
        int              a;
        longint signed   u, num;
        longint unsigned q;
        a   = (ray_axis > 2) ? 2 : ray_axis;
        u   = ray_unit[a];
        num = longint'($signed(ray_cell[a])) * 256 - longint'(ray_origin[a]);
        if (ray_neg[a]) num += 256;
        if (u == 0) return ALL32;
        if (num == 0 || ((num < 0) != (u < 0))) return 32'd0;
        q = (longint'(num < 0 ? -num : num) << 22) / longint'(u < 0 ? -u : u);
        return sat_u32(q);
    endfunction

    function automatic t_out_item predict_ray_result(input t_in_item r);
        t_out_item   res;
        int unsigned steps = 0;
        logic [31:0] hit;
        case (r.operation)
            OP_START: load_ray(r);
            OP_STEP: begin
                walk_one_voxel();
                steps = 1;
            end
            OP_SKIP: steps = skip_to_node(r);
            default: ;
        endcase
        if (r.operation == OP_STEP || r.operation == OP_SKIP) begin
            if (ray_advances < 65535) ray_advances++;
        end
        hit = (r.operation == OP_START) ? 32'd0 : face_distance();
        res.cell_x           = ray_cell[0];
        res.cell_y           = ray_cell[1];
        res.cell_z           = ray_cell[2];
        res.last_axis        = ray_axis;
        res.hit_distance     = hit;
        res.unit_steps_taken = (steps > 65535) ? 16'hFFFF : steps[15:0];
        res.out_of_range     = (hit >= lim_distance);
        res.steps_exhausted  = (ray_advances >= lim_steps);
        return res;
    endfunction

    initial begin
        for (int a = 0; a < 3; a++) begin
            ray_origin[a] = '0;
            ray_unit[a]   = 0;
            ray_delta[a]  = ALL32;
            ray_side[a]   = ALL32;
            ray_cell[a]   = '0;
            ray_neg[a]    = 1'b0;
        end
        ray_axis     = AX_X;
        ray_advances = 0;
    end

    // ------------------------------------------------------------------
    // Monitors: predict on request acceptance, compare on result acceptance.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_item res;
        if (i_rst_n && in_valid && in_ready) begin
            res = predict_ray_result(in_item);
            // Rows with a hand-typed result take that instead of the walker's.
            expected_results.push_back(fixed_pending ? fixed_result : res);
        end
    end

    task automatic flag_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("result %s: expected %0h, got %0h", field, want, got);
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_valid && out_ready) begin
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result %h", out_item);
            end else begin
                want = expected_results.pop_front();
                if (out_item.cell_x !== want.cell_x)
                    flag_field("cell_x", want.cell_x, out_item.cell_x);
                if (out_item.cell_y !== want.cell_y)
                    flag_field("cell_y", want.cell_y, out_item.cell_y);
                if (out_item.cell_z !== want.cell_z)
                    flag_field("cell_z", want.cell_z, out_item.cell_z);
                if (out_item.last_axis !== want.last_axis)
                    flag_field("last_axis", want.last_axis, out_item.last_axis);
                if (out_item.hit_distance !== want.hit_distance)
                    flag_field("hit_distance", want.hit_distance, out_item.hit_distance);
                if (out_item.unit_steps_taken !== want.unit_steps_taken)
                    flag_field("unit_steps_taken", want.unit_steps_taken,
                               out_item.unit_steps_taken);
                if (out_item.out_of_range !== want.out_of_range)
                    flag_field("out_of_range", want.out_of_range, out_item.out_of_range);
                if (out_item.steps_exhausted !== want.steps_exhausted)
                    flag_field("steps_exhausted", want.steps_exhausted,
                               out_item.steps_exhausted);
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall pattern drawn at random from four modes; one long hold-off.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        int unsigned rx_cycle;
        int unsigned rx_mode;
        rx_cycle = rx_cycle + 1;
        if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
        if (rx_cycle >= 20000 && rx_cycle < 23000)
            out_ready <= 1'b0;              // hold off long, let the block back up
        else if (rx_mode == 0)
            out_ready <= 1'b1;
        else if (rx_mode == 1)
            out_ready <= ($urandom_range(0, 1) == 1);
        else if (rx_mode == 2)
            out_ready <= ($urandom_range(0, 3) == 0);
        else
            out_ready <= ($urandom_range(0, 7) != 0);
    end

    // Timeout watchdog.
    always @(posedge i_clk) begin
        int unsigned cycles;
        cycles = cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("voxel_ray_dda_stepper: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sender.
    // ------------------------------------------------------------------
    int unsigned burst_left = 0;
    bit          gaps_on = 1'b1;

    // Offer one request; valid stays up across back-to-back requests.
    task automatic send_request(input t_in_item r, input bit typed, input t_out_item want);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = gaps_on ? $urandom_range(0, 12) : 0;
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        in_item       <= r;
        fixed_pending <= typed;
        fixed_result  <= want;
        in_valid      <= 1'b1;
        do @(posedge i_clk); while (!in_ready);
        @(negedge i_clk);
    endtask

    task automatic idle_sender();
        in_valid      <= 1'b0;
        fixed_pending <= 1'b0;
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_ready);
        if (idx == CFG_MAX_DISTANCE) lim_distance = value;
        else lim_steps = value[15:0];
        @(negedge i_clk);
        cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Wait until every result has come back, then let the block settle.
    task automatic drain_block();
        idle_sender();
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    function automatic t_in_item make_request(input logic [1:0] op,
            input int ox, input int oy, input int oz,
            input int dx, input int dy, input int dz,
            input int lx, input int ly, input int lz);
        t_in_item r;
        r.operation = op;
        r.origin_x = 24'(ox); r.origin_y = 24'(oy); r.origin_z = 24'(oz);
        r.dir_x = 16'(dx); r.dir_y = 16'(dy); r.dir_z = 16'(dz);
        r.child_log_x = 4'(lx); r.child_log_y = 4'(ly); r.child_log_z = 4'(lz);
        return r;
    endfunction

    function automatic t_out_item make_result(input int cx, input int cy, input int cz,
            input int axis, input logic [31:0] hit, input int steps,
            input bit oor, input bit done);
        t_out_item s;
        s.cell_x = 16'(cx); s.cell_y = 16'(cy); s.cell_z = 16'(cz);
        s.last_axis = 2'(axis); s.hit_distance = hit; s.unit_steps_taken = 16'(steps);
        s.out_of_range = oor; s.steps_exhausted = done;
        return s;
    endfunction

    // Random request: every field but the operation random, directions often degenerate.
    function automatic t_in_item random_request(input logic [1:0] op);
        t_in_item r;
        r = t_in_item'($bits(t_in_item)'({$urandom, $urandom, $urandom, $urandom,
                                          $urandom}));
        r.operation = op;
        if ($urandom_range(0, 3) == 0) begin
            r.origin_x = 24'($urandom_range(0, 4095)) - 24'd2048;
            r.origin_y = 24'($urandom_range(0, 4095)) - 24'd2048;
            r.origin_z = 24'($urandom_range(0, 4095)) - 24'd2048;
        end
        case ($urandom_range(0, 15))
            0: begin r.dir_x = '0; r.dir_y = '0; r.dir_z = '0; end
            1: r.dir_x = '0;
            2: r.dir_y = '0;
            3: r.dir_z = '0;
            4: begin r.dir_x = 16'($urandom_range(0, 3)); r.dir_y = '1; end
            default: ;
        endcase
        return r;
    endfunction

    typedef struct {
        t_in_item  req;
        bit        typed;
        t_out_item want;
    } t_table_row;

    t_table_row  directed [$];
    t_out_item   none;
    logic [31:0] phase_dist [PHASES];
    logic [15:0] phase_steps [PHASES];
    int unsigned sent;
    int unsigned walk_len;

    initial begin
        none = '0;
        // After reset: zero direction means saturated hit distance.
        directed.push_back('{make_request(OP_NOP, 0,0,0, 0,0,0, 0,0,0), 1'b1,
                             make_result(0,0,0, AX_X, ALL32, 0, 1'b1, 1'b0)});
        directed.push_back('{make_request(OP_START, 8388607,8388607,8388607,
                             16384,0,0, 0,0,0), 1'b1,
                             make_result(32767,32767,32767, AX_X, 32'd0, 0, 1'b0, 1'b0)});
        directed.push_back('{make_request(OP_STEP, 0,0,0, 0,0,0, 0,0,0), 1'b0, none});
        directed.push_back('{make_request(OP_SKIP, 0,0,0, 0,0,0, 0,0,0), 1'b0, none});
        directed.push_back('{make_request(OP_SKIP, 0,0,0, 0,0,0, 15,15,15), 1'b0, none});
        directed.push_back('{make_request(OP_START, -8388608,-8388608,-8388608,
                             -32768,-32768,-32768, 15,15,15), 1'b1,
                             make_result(-32768,-32768,-32768, AX_X, 32'd0, 0, 1'b0, 1'b0)});
        directed.push_back('{make_request(OP_STEP, 0,0,0, 0,0,0, 0,0,0), 1'b0, none});
        directed.push_back('{make_request(OP_SKIP, 0,0,0, 0,0,0, 15,15,15), 1'b0, none});
        directed.push_back('{make_request(OP_SKIP, 0,0,0, 0,0,0, 7,8,6), 1'b0, none});
        // Zero direction: every axis steps positive with saturated distances.
        directed.push_back('{make_request(OP_START, 300,-300,1, 0,0,0, 0,0,0), 1'b1,
                             make_result(1,-2,0, AX_X, 32'd0, 0, 1'b0, 1'b0)});
        directed.push_back('{make_request(OP_STEP, 0,0,0, 0,0,0, 0,0,0), 1'b1,
                             make_result(1,-2,1, AX_Z, ALL32, 1, 1'b1, 1'b0)});
        directed.push_back('{make_request(OP_SKIP, 0,0,0, 0,0,0, 2,2,2), 1'b0, none});
        directed.push_back('{make_request(OP_NOP, -1,-1,-1, -1,-1,-1, 15,15,15), 1'b0, none});
        // Tiny components lost to truncation.
        directed.push_back('{make_request(OP_START, 128,-129,255, 32767,-1,1, 0,0,0),
                             1'b0, none});
        directed.push_back('{make_request(OP_STEP, 0,0,0, 0,0,0, 0,0,0), 1'b0, none});
        directed.push_back('{make_request(OP_SKIP, 0,0,0, 0,0,0, 3,3,3), 1'b0, none});
        // Backward step sitting on a node boundary: single voxel only.
        directed.push_back('{make_request(OP_START, 0,0,0, -100,-200,-300, 0,0,0),
                             1'b0, none});
        directed.push_back('{make_request(OP_SKIP, 0,0,0, 0,0,0, 3,3,3), 1'b0, none});
        directed.push_back('{make_request(OP_SKIP, 0,0,0, 0,0,0, 3,3,3), 1'b0, none});
        directed.push_back('{make_request(OP_START, 12345,-777,40000, 5000,-9000,12000,
                             0,0,0), 1'b0, none});
        directed.push_back('{make_request(OP_SKIP, 0,0,0, 0,0,0, 4,1,9), 1'b0, none});
        directed.push_back('{make_request(OP_STEP, 0,0,0, 0,0,0, 0,0,0), 1'b0, none});

        phase_dist[0] = 32'd0;           phase_steps[0] = 16'd1;
        phase_dist[1] = ALL32;           phase_steps[1] = 16'hFFFF;
        phase_dist[2] = 32'd16777216;    phase_steps[2] = 16'd1024;
        phase_dist[3] = $urandom_range(32'h0001_0000, 32'h0400_0000);
        phase_steps[3] = 16'($urandom_range(2, 12));
        phase_dist[4] = $urandom;        phase_steps[4] = 16'($urandom_range(1, 65535));

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed[k])
            send_request(directed[k].req, directed[k].typed, directed[k].want);
        drain_block();

        // Random walks: mostly a start followed by advances, some noise.
        sent = 0;
        for (int p = 0; p < PHASES; p++) begin
            write_register(CFG_MAX_DISTANCE, phase_dist[p]);
            write_register(CFG_MAX_STEPS, {16'd0, phase_steps[p]});
            gaps_on = (p != 2);
            while (sent < (p + 1) * RANDOM_ITEMS / PHASES) begin
                send_request(random_request(OP_START), 1'b0, none);
                sent++;
                walk_len = $urandom_range(1, 14);
                repeat (walk_len) begin
                    case ($urandom_range(0, 19))
                        0:       send_request(random_request(OP_NOP), 1'b0, none);
                        1:       send_request(random_request(2'($urandom)), 1'b0, none);
                        2,3,4,5,6,7,8,9,10:
                                 send_request(random_request(OP_STEP), 1'b0, none);
                        default: send_request(random_request(OP_SKIP), 1'b0, none);
                    endcase
                    sent++;
                end
            end
            drain_block();
        end

        if (mismatch_count == 0)
            $display("voxel_ray_dda_stepper: match");
        else
            $display("voxel_ray_dda_stepper: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
